@@ hw/rtl/mtrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mtrd_pkg;

    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    typedef enum logic [1:0] {
        KIND_SEND_STATUS = 2'd0,
        KIND_FORWARD     = 2'd1,
        KIND_SUMMARY     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SEND_ACCEPTED       = 2'd0,
        SEND_REJECTED_FULL  = 2'd1,
        SEND_CLIENT_WAITING = 2'd2
    } send_status_t;

    typedef enum logic [1:0] {
        CTL_IDLE  = 2'b01,
        CTL_DRAIN = 2'b10
    } ctl_state_t;

    // input word, message in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [31:0] incoming_word;
        logic [2:0]  local_occupied;
        logic [2:0]  peer_free;
        logic        blocking;
        logic [31:0] message;
    } in_word_t;

    // result word, send_status in the lowest bits
    typedef struct packed {
        logic [1:0]   pad;
        logic         remove_pulse;
        logic [31:0]  rx_word;
        logic         rx_valid;
        logic         wake_client;
        logic         free_irq_enable;
        logic [31:0]  forward_word;
        send_status_t send_status;
    } out_word_t;

    localparam int IN_TDATA_W  = $bits(in_word_t);
    localparam int OUT_TDATA_W = $bits(out_word_t);

    typedef struct packed {
        logic accept_send;
        logic accept_service;
        logic emit_forward;
        logic emit_summary;
    } dp_cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic budget_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/mailbox_tx_ring_drain_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Outbound mailbox queue. A send word (tuser = 0) stores its message in a ring
// of RING_DEPTH entries that holds at most RING_DEPTH-1 words and returns one
// status word in the cycle after it is taken. A service word (tuser = 1) forwards
// up to peer_free queued words, one result word per cycle while the result side
// takes them, and closes with a summary word (tlast high) that carries the
// interrupt enable, the client wake and the received word. Between 0 and 7
// words are forwarded per service word; the single read port of the ring sets
// the one word per cycle drain. Back-pressure on the result side stalls it.
// No clearing pass is needed after reset.
module mailbox_tx_ring_drain_core
    import mtrd_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // message[31:0], blocking[32], peer_free[35:33], local_occupied[38:36],
    // incoming_word[70:39], zero[71]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic [0:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // send_status[1:0], forward_word[33:2], free_irq_enable[34],
    // wake_client[35], rx_valid[36], rx_word[68:37], remove_pulse[69], zero[71:70]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [0:0]             cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mtrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtrd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_bit   (cfg_data[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mtrd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mtrd_ctrl
    import mtrd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     op,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign s_tready = (state_reg == CTL_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_SEND)
                    begin
                        cmd.accept_send = 1'b1;
                    end
                    else
                    begin
                        cmd.accept_service = 1'b1;
                        state_next         = CTL_DRAIN;
                    end
                end
            end
            CTL_DRAIN:
            begin
                // forward while budget and words remain, then close with summary
                if (stat.out_free)
                begin
                    if (!stat.budget_zero && !stat.ring_empty)
                    begin
                        cmd.emit_forward = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_summary = 1'b1;
                        state_next       = CTL_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mtrd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mtrd_datapath
    import mtrd_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    input  wire logic [IN_TDATA_W-1:0]  in_data,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_bit,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OUT_TDATA_W-1:0]      out_data,
    output logic [1:0]                  out_kind,
    output logic                        out_last
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    in_word_t         in_w;

    logic [31:0]      ring [RING_DEPTH];
    logic [31:0]      rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             waiting_reg, waiting_next;
    logic             irq_reg, irq_next;
    logic             rx_en_reg;

    logic [2:0]       budget_reg, budget_next;
    logic             was_nonempty_reg;
    logic             occ_nz_reg;
    logic [31:0]      inword_reg;

    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;
    kind_t            out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;

    logic             ring_full;
    logic             ring_empty;
    logic             out_free;
    logic             wr_en;
    logic             drain_irq;

    assign in_w       = in_word_t'(in_data);
    assign ring_empty = (head_reg == tail_reg);
    assign ring_full  = (slot_inc(tail_reg) == head_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign wr_en      = cmd.accept_send && !ring_full;
    assign drain_irq  = was_nonempty_reg ? !ring_empty : irq_reg;

    assign stat.ring_empty  = ring_empty;
    assign stat.budget_zero = (budget_reg == 3'd0);
    assign stat.out_free    = out_free;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        waiting_next   = waiting_reg;
        irq_next       = irq_reg;
        budget_next    = budget_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.accept_send)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_SEND_STATUS;
            out_last_next  = 1'b1;
            out_data_next  = '0;
            if (ring_full)
            begin
                if (in_w.blocking)
                begin
                    waiting_next              = 1'b1;
                    out_data_next.send_status = SEND_CLIENT_WAITING;
                end
                else
                begin
                    out_data_next.send_status = SEND_REJECTED_FULL;
                end
            end
            else
            begin
                tail_next                     = slot_inc(tail_reg);
                irq_next                      = 1'b1;
                out_data_next.send_status     = SEND_ACCEPTED;
                out_data_next.free_irq_enable = 1'b1;
            end
        end

        if (cmd.accept_service)
        begin
            budget_next = in_w.peer_free;
        end

        if (cmd.emit_forward)
        begin
            head_next                  = slot_inc(head_reg);
            budget_next                = budget_reg - 3'd1;
            out_valid_next             = 1'b1;
            out_kind_next              = KIND_FORWARD;
            out_last_next              = 1'b0;
            out_data_next              = '0;
            out_data_next.forward_word = rd_data_reg;
        end

        if (cmd.emit_summary)
        begin
            out_valid_next                = 1'b1;
            out_kind_next                 = KIND_SUMMARY;
            out_last_next                 = 1'b1;
            out_data_next                 = '0;
            irq_next                      = drain_irq;
            out_data_next.free_irq_enable = drain_irq;
            // wake only after a drain of a non-empty ring that left room
            if (was_nonempty_reg && waiting_reg && !ring_full)
            begin
                waiting_next              = 1'b0;
                out_data_next.wake_client = 1'b1;
            end
            if (occ_nz_reg && rx_en_reg)
            begin
                out_data_next.rx_valid     = 1'b1;
                out_data_next.rx_word      = inword_reg;
                out_data_next.remove_pulse = 1'b1;
            end
        end
    end

    // ring memory, read port follows the next head with write-through
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[tail_reg] <= in_w.message;
        end
        if (wr_en && (tail_reg == head_next))
        begin
            rd_data_reg <= in_w.message;
        end
        else
        begin
            rd_data_reg <= ring[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            waiting_reg   <= 1'b0;
            irq_reg       <= 1'b0;
            rx_en_reg     <= 1'b0;
            budget_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            waiting_reg   <= waiting_next;
            irq_reg       <= irq_next;
            budget_reg    <= budget_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                rx_en_reg <= cfg_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        if (cmd.accept_service)
        begin
            was_nonempty_reg <= !ring_empty;
            occ_nz_reg       <= (in_w.local_occupied != 3'd0);
            inword_reg       <= in_w.incoming_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
